@@ sv/amrt_pkg.sv @@
// amrt_pkg: shared types and constants for the adaptive memory reserve tracker
// register widths, register indexes, reset values and the sequencer state type
// no dependencies
package amrt_pkg;

    // configuration field widths
    localparam int LIM_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int GRAN_W     = 24;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // default structure sizes
    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_RUN_DEPTH    = 64;
    localparam int DEF_SAMPLE_BITS  = 24;

    // configuration reset values
    localparam logic [LIM_W-1:0]  RST_TOTAL_LIMIT     = 24'd0;
    localparam logic [LIM_W-1:0]  RST_INITIAL_RESERVE = 24'd0;
    localparam logic [FRAC_W-1:0] RST_MIN_GUARD       = 16'd0;
    localparam logic [FRAC_W-1:0] RST_GUARD_MULT      = 16'd8192;
    localparam logic [FRAC_W-1:0] RST_CLOSENESS       = 16'd58982;
    localparam logic [GRAN_W-1:0] RST_GRANULE         = 24'd1024;
    localparam logic [LEN_W-1:0]  RST_WINDOW_LEN      = 7'd8;
    localparam logic [LEN_W-1:0]  RST_PHASE_LEN       = 7'd4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_LIMIT     = 3'd0,
        CFG_INITIAL_RESERVE = 3'd1,
        CFG_MIN_GUARD       = 3'd2,
        CFG_GUARD_MULT      = 3'd3,
        CFG_CLOSENESS       = 3'd4,
        CFG_GRANULE         = 3'd5,
        CFG_WINDOW_LEN      = 3'd6,
        CFG_PHASE_LEN       = 3'd7
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_SQRT,
        S_ST0,
        S_ST1,
        S_ST2,
        S_ST3,
        S_ST4,
        S_ST5,
        S_ST6,
        S_G0,
        S_G1,
        S_G2,
        S_DV0,
        S_DV1,
        S_PU0,
        S_PU1,
        S_PU2,
        S_PU3,
        S_PU4,
        S_FCHK,
        S_DEC0,
        S_DEC1,
        S_DEC2,
        S_DEC3,
        S_CPI,
        S_CPR,
        S_CPD,
        S_CPS,
        S_REB,
        S_FIN
    } t_state;

endpackage

@@ sv/amrt_ram.sv @@
// amrt_ram: generic single write port, single read port memory
// read data is registered; depends on nothing
module amrt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/adaptive_memory_reserve_tracker.sv @@
// adaptive_memory_reserve_tracker: windowed mean/std reserve tracker, top level
// uses amrt_pkg and two amrt_ram instances (sample window, low-run store)
// Flow: a steady item runs a statistics pass (bit-serial mean and variance divisions, a
// square root), the guard, the window update and the reserve decision; a reserve raise adds
// one more division, a rebase a copy of each run entry and one more statistics pass.
// Input: one item at a time, o_stall high until the sequencer is idle again; divider and
// square root dominate. The next item is taken while a result waits in the output register.
// Reset: synchronous, active low; clears control state and loads register defaults.
// The two sample memories are not cleared, entries are read only after being written.
module adaptive_memory_reserve_tracker
    import amrt_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int RUN_DEPTH    = DEF_RUN_DEPTH,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SAMPLE_BITS-1:0]        i_sample_mb,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [SAMPLE_BITS-1:0]        o_fg_reserve,
    output logic signed [SAMPLE_BITS:0]   o_bg_reserve,
    output logic signed [SAMPLE_BITS:0]   o_bg_spare,
    output logic signed [SAMPLE_BITS:0]   o_lower_bound,
    output logic [SAMPLE_BITS-1:0]        o_window_mean,
    output logic [SAMPLE_BITS-1:0]        o_window_std,
    output logic                          o_violation,
    output logic                          o_phase_change,
    output logic                          o_filling
);

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int RAW    = $clog2(RUN_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int RCNT_W = $clog2(RUN_DEPTH + 1);
    localparam int SUM_W  = SB + CNT_W;
    localparam int SQ_W   = 2 * SB + CNT_W;
    localparam int M_W    = (SUM_W > LIM_W) ? SUM_W : LIM_W;
    localparam int DV_W   = 2 * SB + 2 * CNT_W;
    localparam int DS_W   = (2 * CNT_W > GRAN_W) ? 2 * CNT_W : GRAN_W;
    localparam int G_W    = (SB + 4 > LIM_W) ? SB + 4 : LIM_W;
    localparam int X_W    = G_W + 3;
    localparam int P_W    = X_W + 17;
    localparam int HO_W   = CNT_W + 1;
    localparam int IT_W   = $clog2(DV_W + 1);
    localparam logic signed [X_W-1:0] SMAX = X_W'((64'd1 << SB) - 64'd1);

    // saturate to the unsigned sample range
    function automatic logic [SB-1:0] sat_u(input logic signed [X_W-1:0] v);
        logic [SB-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SMAX) begin
            res = SMAX[SB-1:0];
        end else begin
            res = v[SB-1:0];
        end
        return res;
    endfunction

    // saturate to the symmetric signed range
    function automatic logic signed [SB:0] sat_s(input logic signed [X_W-1:0] v);
        logic signed [SB:0] res;
        if (v < -SMAX) begin
            res = -SMAX[SB:0];
        end else if (v > SMAX) begin
            res = SMAX[SB:0];
        end else begin
            res = v[SB:0];
        end
        return res;
    endfunction

    // configuration registers
    logic [LIM_W-1:0]  r_total_limit;
    logic [LIM_W-1:0]  r_initial_reserve;
    logic [FRAC_W-1:0] r_min_guard;
    logic [FRAC_W-1:0] r_guard_mult;
    logic [FRAC_W-1:0] r_closeness;
    logic [GRAN_W-1:0] r_granule;
    logic [LEN_W-1:0]  r_window_len;
    logic [LEN_W-1:0]  r_phase_len;

    // sequencer
    t_state r_state, n_state, r_ret, r_dret;

    // tracker state
    logic [AW-1:0]          r_head;
    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]        r_sq;
    logic [RCNT_W-1:0]      r_run_cnt;
    logic [RCNT_W-1:0]      r_idx;
    logic [SB-1:0]          r_reserve;
    logic signed [X_W-1:0]  r_bg;
    logic signed [X_W-1:0]  r_spare;
    logic signed [SB:0]     r_bound;
    logic signed [HO_W-1:0] r_holdoff;
    logic                   r_fill;

    // per-item working registers
    logic [SB-1:0]          r_sample;
    logic [SB-1:0]          r_mean;
    logic [SB-1:0]          r_sd;
    logic [G_W-1:0]         r_gfloor;
    logic [G_W-1:0]         r_guard;
    logic signed [X_W-1:0]  r_cur;
    logic                   r_viol;
    logic                   r_phase;

    // shared multiplier, divider and square root registers
    logic [2*M_W-1:0]       r_prod;
    logic [DV_W-1:0]        r_acc;
    logic [DV_W-1:0]        r_dvd;
    logic [DS_W-1:0]        r_dvs;
    logic [DS_W-1:0]        r_rem;
    logic [IT_W-1:0]        r_it;
    logic [2*SB-1:0]        r_rad;
    logic [SB+1:0]          r_srem;
    logic [SB-1:0]          r_root;
    logic                   r_dneg;

    // output register
    logic                   r_ov;
    logic [SB-1:0]          r_o_fg;
    logic signed [SB:0]     r_o_bg;
    logic signed [SB:0]     r_o_spare;
    logic signed [SB:0]     r_o_bound;
    logic [SB-1:0]          r_o_mean;
    logic [SB-1:0]          r_o_sd;
    logic                   r_o_viol;
    logic                   r_o_phase;
    logic                   r_o_fill;

    // combinational helpers
    logic [M_W-1:0]         m_a, m_b;
    logic [CNT_W-1:0]       eff_win;
    logic [RCNT_W-1:0]      eff_ph;
    logic                   drop_old;
    logic [CNT_W:0]         widx_sum;
    logic [AW-1:0]          widx;
    logic [DS_W:0]          div_t;
    logic                   div_ge;
    logic [SB+3:0]          sq_t;
    logic [SB+3:0]          sq_trial;
    logic                   sq_ge;
    logic signed [X_W-1:0]  g_s;
    logic signed [X_W-1:0]  mean_s;
    logic signed [X_W-1:0]  samp_s;
    logic signed [X_W-1:0]  d_s;
    logic signed [X_W-1:0]  d_mag;
    logic signed [X_W-1:0]  rem_s;
    logic signed [P_W-1:0]  thr_s;
    logic                   c1, c2;
    logic signed [X_W-1:0]  cur1;
    logic signed [HO_W-1:0] ho_dec;
    logic                   in_acc;
    logic                   out_free;

    // memory ports
    logic                   win_we;
    logic [AW-1:0]          win_waddr;
    logic [SB-1:0]          win_wdata;
    logic [AW-1:0]          win_raddr;
    logic [SB-1:0]          win_rdata;
    logic                   run_we;
    logic [RAW-1:0]         run_waddr;
    logic [SB-1:0]          run_wdata;
    logic [RAW-1:0]         run_raddr;
    logic [SB-1:0]          run_rdata;

    amrt_ram #(.WIDTH(SB), .DEPTH(WINDOW_DEPTH)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (win_wdata),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    amrt_ram #(.WIDTH(SB), .DEPTH(RUN_DEPTH)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (run_waddr),
        .i_wdata (run_wdata),
        .i_raddr (run_raddr),
        .o_rdata (run_rdata)
    );

    // effective lengths and window indexing
    always_comb begin
        if (r_window_len == '0) begin
            eff_win = CNT_W'(1);
        end else if (int'(r_window_len) > WINDOW_DEPTH) begin
            eff_win = CNT_W'(WINDOW_DEPTH);
        end else begin
            eff_win = CNT_W'(r_window_len);
        end
        if (r_phase_len == '0) begin
            eff_ph = RCNT_W'(1);
        end else if (int'(r_phase_len) > RUN_DEPTH) begin
            eff_ph = RCNT_W'(RUN_DEPTH);
        end else begin
            eff_ph = RCNT_W'(r_phase_len);
        end
        drop_old = (r_cnt >= eff_win) && (r_cnt != '0);
        widx_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_cnt);
        if (widx_sum >= (CNT_W+1)'(WINDOW_DEPTH)) begin
            widx = AW'(widx_sum - (CNT_W+1)'(WINDOW_DEPTH));
        end else begin
            widx = AW'(widx_sum);
        end
    end

    // divider and square root step
    always_comb begin
        div_t    = {r_rem, r_dvd[DV_W-1]};
        div_ge   = div_t >= {1'b0, r_dvs};
        sq_t     = {r_srem, r_rad[2*SB-1 -: 2]};
        sq_trial = (SB+4)'({r_root, 2'b01});
        sq_ge    = sq_t >= sq_trial;
    end

    // signed working values for reserve decisions
    always_comb begin
        g_s    = $signed(X_W'(r_guard));
        mean_s = $signed(X_W'(r_mean));
        samp_s = $signed(X_W'(r_sample));
        d_s    = $signed(X_W'(r_total_limit)) - $signed(X_W'(r_reserve));
        d_mag  = (d_s < 0) ? -d_s : d_s;
        rem_s  = $signed(X_W'(r_rem));
        thr_s  = $signed(P_W'(r_prod[SB+FRAC_W-1:0]));
        c1     = (P_W'(samp_s) <<< 16) >= thr_s;
        cur1   = c1 ? samp_s - r_spare : samp_s;
        c2     = (P_W'(cur1) <<< 16) >= thr_s;
        ho_dec = (r_holdoff > 0) ? r_holdoff - HO_W'(1) : r_holdoff;
    end

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = r_fill ? S_DV0 : S_ST0;
                end
            end
            S_DIV:  n_state = (r_it == IT_W'(1)) ? r_dret : S_DIV;
            S_SQRT: n_state = (r_it == IT_W'(1)) ? S_G0 : S_SQRT;
            S_ST0:  n_state = (r_cnt == '0) ? S_G0 : S_DIV;
            S_ST1:  n_state = S_ST2;
            S_ST2:  n_state = S_ST3;
            S_ST3:  n_state = S_ST4;
            S_ST4:  n_state = (r_acc > DV_W'(r_prod)) ? S_ST5 : S_G0;
            S_ST5:  n_state = S_DIV;
            S_ST6:  n_state = S_SQRT;
            S_G0:   n_state = S_G1;
            S_G1:   n_state = S_G2;
            S_G2:   n_state = r_ret;
            S_DV0:  n_state = S_DIV;
            S_DV1:  n_state = r_ret;
            S_PU0:  n_state = drop_old ? S_PU1 : S_PU3;
            S_PU1:  n_state = S_PU2;
            S_PU2:  n_state = S_PU3;
            S_PU3:  n_state = S_PU4;
            S_PU4:  n_state = r_fill ? S_FCHK : S_DEC0;
            S_FCHK: n_state = (r_cnt >= eff_win) ? S_ST0 : S_FIN;
            S_DEC0: n_state = S_DEC1;
            S_DEC1: n_state = c2 ? S_DV0 : S_DEC2;
            S_DEC2: n_state = S_DEC3;
            S_DEC3: n_state = (r_run_cnt >= eff_ph) ? S_CPI : S_FIN;
            S_CPI:  n_state = S_CPR;
            S_CPR:  n_state = (r_idx < r_run_cnt) ? S_CPD : S_ST0;
            S_CPD:  n_state = S_CPS;
            S_CPS:  n_state = S_CPR;
            S_REB:  n_state = S_DV0;
            S_FIN:  n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // shared multiplier operands and memory controls
    always_comb begin
        m_a       = '0;
        m_b       = '0;
        win_we    = 1'b0;
        win_waddr = widx;
        win_wdata = r_sample;
        win_raddr = r_head;
        run_we    = 1'b0;
        run_waddr = r_run_cnt[RAW-1:0];
        run_wdata = sat_u(r_cur);
        run_raddr = r_idx[RAW-1:0];
        o_stall   = (r_state != S_IDLE);
        case (r_state)
            S_ST1: begin
                m_a = M_W'(r_sq[M_W-1:0]);
                m_b = M_W'(r_cnt);
            end
            S_ST2: begin
                m_a = M_W'(r_sq[SQ_W-1:M_W]);
                m_b = M_W'(r_cnt);
            end
            S_ST3: begin
                m_a = M_W'(r_sum);
                m_b = M_W'(r_sum);
            end
            S_ST4: begin
                m_a = M_W'(r_cnt);
                m_b = M_W'(r_cnt);
            end
            S_G0: begin
                m_a = M_W'(r_min_guard);
                m_b = M_W'(r_total_limit);
            end
            S_G1: begin
                m_a = M_W'(r_guard_mult);
                m_b = M_W'(r_sd);
            end
            S_DEC0: begin
                m_a = M_W'(r_closeness);
                m_b = M_W'(r_reserve);
            end
            S_PU1: begin
                m_a = M_W'(win_rdata);
                m_b = M_W'(win_rdata);
            end
            S_PU3: begin
                m_a    = M_W'(r_sample);
                m_b    = M_W'(r_sample);
                win_we = 1'b1;
            end
            S_CPD: begin
                m_a       = M_W'(run_rdata);
                m_b       = M_W'(run_rdata);
                win_we    = 1'b1;
                win_waddr = r_cnt[AW-1:0];
                win_wdata = run_rdata;
            end
            S_DEC2: begin
                run_we = (r_cur < $signed(X_W'(r_bound))) &&
                         (r_run_cnt < RCNT_W'(RUN_DEPTH));
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_limit     <= RST_TOTAL_LIMIT;
            r_initial_reserve <= RST_INITIAL_RESERVE;
            r_min_guard       <= RST_MIN_GUARD;
            r_guard_mult      <= RST_GUARD_MULT;
            r_closeness       <= RST_CLOSENESS;
            r_granule         <= RST_GRANULE;
            r_window_len      <= RST_WINDOW_LEN;
            r_phase_len       <= RST_PHASE_LEN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOTAL_LIMIT:     r_total_limit     <= i_cfg_data[LIM_W-1:0];
                CFG_INITIAL_RESERVE: r_initial_reserve <= i_cfg_data[LIM_W-1:0];
                CFG_MIN_GUARD:       r_min_guard       <= i_cfg_data[FRAC_W-1:0];
                CFG_GUARD_MULT:      r_guard_mult      <= i_cfg_data[FRAC_W-1:0];
                CFG_CLOSENESS:       r_closeness       <= i_cfg_data[FRAC_W-1:0];
                CFG_GRANULE:         r_granule         <= i_cfg_data[GRAN_W-1:0];
                CFG_WINDOW_LEN:      r_window_len      <= i_cfg_data[LEN_W-1:0];
                CFG_PHASE_LEN:       r_phase_len       <= i_cfg_data[LEN_W-1:0];
                default:             r_total_limit     <= r_total_limit;
            endcase
        end
    end

    // product register of the shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // tracker control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_run_cnt <= '0;
            r_reserve <= '0;
            r_bg      <= '0;
            r_spare   <= '0;
            r_bound   <= '0;
            r_holdoff <= '1;
            r_fill    <= 1'b1;
            r_ret     <= S_IDLE;
            r_dret    <= S_IDLE;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ret <= S_PU0;
                        if (r_fill) begin
                            r_reserve <= sat_u($signed(X_W'(r_initial_reserve)));
                        end
                    end
                end
                S_ST0: begin
                    r_dret <= S_ST1;
                end
                S_ST5: begin
                    r_dret <= S_ST6;
                end
                S_DV0: begin
                    r_dret <= S_DV1;
                end
                S_DV1: begin
                    r_spare <= r_dneg ? -rem_s : rem_s;
                    r_bg    <= d_s - (r_dneg ? -rem_s : rem_s);
                end
                S_PU1: begin
                    r_sum <= r_sum - SUM_W'(win_rdata);
                end
                S_PU2: begin
                    r_sq   <= r_sq - SQ_W'(r_prod);
                    r_head <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);
                    r_cnt  <= r_cnt - CNT_W'(1);
                end
                S_PU3: begin
                    r_sum <= r_sum + SUM_W'(r_sample);
                end
                S_PU4: begin
                    r_sq  <= r_sq + SQ_W'(r_prod);
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                S_FCHK: begin
                    r_ret <= S_REB;
                end
                S_DEC0: begin
                    if (ho_dec == '0) begin
                        r_bound   <= sat_s(mean_s - g_s);
                        r_holdoff <= '1;
                    end else begin
                        r_holdoff <= ho_dec;
                    end
                end
                S_DEC1: begin
                    if (c1) begin
                        r_spare <= '0;
                    end
                    if (c2) begin
                        r_reserve <= sat_u(cur1 + g_s);
                        r_bound   <= sat_s(cur1 - g_s);
                        r_holdoff <= HO_W'(eff_win);
                        r_ret     <= S_DEC2;
                    end
                end
                S_DEC2: begin
                    if (r_cur < $signed(X_W'(r_bound))) begin
                        if (r_run_cnt < RCNT_W'(RUN_DEPTH)) begin
                            r_run_cnt <= r_run_cnt + RCNT_W'(1);
                        end
                    end else begin
                        r_run_cnt <= '0;
                    end
                end
                S_CPI: begin
                    r_head <= '0;
                    r_cnt  <= '0;
                    r_sum  <= '0;
                    r_sq   <= '0;
                    r_ret  <= S_REB;
                end
                S_CPD: begin
                    r_sum <= r_sum + SUM_W'(run_rdata);
                end
                S_CPS: begin
                    r_sq  <= r_sq + SQ_W'(r_prod);
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                S_REB: begin
                    r_reserve <= sat_u(mean_s + g_s);
                    r_bound   <= sat_s(mean_s - g_s);
                    r_run_cnt <= '0;
                    r_fill    <= 1'b0;
                    r_ret     <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                    end
                end
                default: begin
                    r_ret <= r_ret;
                end
            endcase
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_sample <= i_sample_mb;
                    r_mean   <= '0;
                    r_sd     <= '0;
                    r_viol   <= 1'b0;
                    r_phase  <= 1'b0;
                end
            end
            S_DIV: begin
                r_rem <= div_ge ? DS_W'(div_t - {1'b0, r_dvs}) : DS_W'(div_t);
                r_dvd <= {r_dvd[DV_W-2:0], div_ge};
                r_it  <= r_it - IT_W'(1);
            end
            S_SQRT: begin
                r_srem <= sq_ge ? (SB+2)'(sq_t - sq_trial) : (SB+2)'(sq_t);
                r_root <= {r_root[SB-2:0], sq_ge};
                r_rad  <= r_rad << 2;
                r_it   <= r_it - IT_W'(1);
                if (r_it == IT_W'(1)) begin
                    r_sd <= {r_root[SB-2:0], sq_ge};
                end
            end
            S_ST0: begin
                r_mean <= '0;
                r_sd   <= '0;
                r_dvd  <= DV_W'(r_sum);
                r_dvs  <= DS_W'(r_cnt);
                r_rem  <= '0;
                r_it   <= IT_W'(DV_W);
            end
            S_ST1: begin
                r_mean <= r_dvd[SB-1:0];
            end
            S_ST2: begin
                r_acc <= DV_W'(r_prod);
            end
            S_ST3: begin
                r_acc <= r_acc + (DV_W'(r_prod) << M_W);
            end
            S_ST4: begin
                r_acc <= r_acc - DV_W'(r_prod);
            end
            S_ST5: begin
                r_dvd <= r_acc;
                r_dvs <= DS_W'(r_prod);
                r_rem <= '0;
                r_it  <= IT_W'(DV_W);
            end
            S_ST6: begin
                r_rad  <= r_dvd[2*SB-1:0];
                r_srem <= '0;
                r_root <= '0;
                r_it   <= IT_W'(SB);
            end
            S_G1: begin
                r_gfloor <= G_W'(r_prod >> FRAC_W);
            end
            S_G2: begin
                r_guard <= (r_gfloor > G_W'(r_prod >> 12)) ? r_gfloor : G_W'(r_prod >> 12);
            end
            S_DV0: begin
                r_dvd  <= DV_W'(d_mag);
                r_dvs  <= (r_granule == '0) ? DS_W'(1) : DS_W'(r_granule);
                r_rem  <= '0;
                r_it   <= IT_W'(DV_W);
                r_dneg <= d_s < 0;
            end
            S_DEC1: begin
                r_cur <= cur1;
                if (c2) begin
                    r_viol <= 1'b1;
                end
            end
            S_CPI: begin
                r_idx <= (r_run_cnt > RCNT_W'(WINDOW_DEPTH)) ?
                         r_run_cnt - RCNT_W'(WINDOW_DEPTH) : '0;
            end
            S_CPS: begin
                r_idx <= r_idx + RCNT_W'(1);
            end
            S_REB: begin
                r_phase <= !r_fill;
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_o_fg    <= r_reserve;
            r_o_bg    <= r_bg[SB:0];
            r_o_spare <= r_spare[SB:0];
            r_o_bound <= r_bound;
            r_o_mean  <= r_mean;
            r_o_sd    <= r_sd;
            r_o_viol  <= r_viol;
            r_o_phase <= r_phase;
            r_o_fill  <= r_fill;
        end
    end

    assign o_valid        = r_ov;
    assign o_fg_reserve   = r_o_fg;
    assign o_bg_reserve   = r_o_bg;
    assign o_bg_spare     = r_o_spare;
    assign o_lower_bound  = r_o_bound;
    assign o_window_mean  = r_o_mean;
    assign o_window_std   = r_o_sd;
    assign o_violation    = r_o_viol;
    assign o_phase_change = r_o_phase;
    assign o_filling      = r_o_fill;

    // window occupancy never exceeds the store
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW_DEPTH))
        else $error("window count beyond depth");

    // low run never exceeds its store
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= RCNT_W'(RUN_DEPTH))
        else $error("low run count beyond depth");

    // fill phase ends once and does not come back
    a_fill_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fill |=> !r_fill)
        else $error("fill phase re-entered");

    // a filling item never reports a raise or a rebase
    a_fill_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_fill) |-> (!r_o_viol && !r_o_phase))
        else $error("flags set on a filling item");

    // holdoff stays between idle and the window length
    a_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_holdoff >= -1) && (r_holdoff <= $signed(HO_W'(WINDOW_DEPTH))))
        else $error("holdoff out of range");

endmodule

@@ tb/adaptive_memory_reserve_tracker_tb.sv @@
// adaptive_memory_reserve_tracker_tb: self-checking bench for the reserve tracker
// predicts every result item in-bench and compares it field by field
// depends on amrt_pkg and the adaptive_memory_reserve_tracker top level
module adaptive_memory_reserve_tracker_tb;
    import amrt_pkg::*;

    localparam int     SBITS       = DEF_SAMPLE_BITS;
    localparam int     WDEPTH      = DEF_WINDOW_DEPTH;
    localparam int     RDEPTH      = DEF_RUN_DEPTH;
    localparam longint SMAX        = (64'd1 << SBITS) - 1;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [SBITS-1:0]        fg;
        logic signed [SBITS:0]   bg;
        logic signed [SBITS:0]   spare;
        logic signed [SBITS:0]   bound;
        logic [SBITS-1:0]        mean;
        logic [SBITS-1:0]        sd;
        logic                    viol;
        logic                    phase;
        logic                    fill;
    } reserve_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [SBITS-1:0]       i_sample_mb = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [SBITS-1:0]       o_fg_reserve;
    logic signed [SBITS:0]  o_bg_reserve;
    logic signed [SBITS:0]  o_bg_spare;
    logic signed [SBITS:0]  o_lower_bound;
    logic [SBITS-1:0]       o_window_mean;
    logic [SBITS-1:0]       o_window_std;
    logic                   o_violation;
    logic                   o_phase_change;
    logic                   o_filling;

    adaptive_memory_reserve_tracker dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state: configuration copy
    longint unsigned lim_r, init_r, guard_frac_r, mult_r, close_r, gran_r, wlen_r, plen_r;
    // predictor state: window and low run
    longint unsigned win_mem [WDEPTH];
    longint unsigned run_mem [RDEPTH];
    int              win_head, win_cnt, run_cnt;
    longint unsigned win_sum, win_sq;
    longint          resv, bg_cur, spare_cur, bound_cur;
    int              hold;
    bit              filling_now;

    reserve_result_t expected_q[$];
    int  mismatches = 0;
    int  results_seen = 0, viol_seen = 0, phase_seen = 0, fill_seen = 0;
    bit  quiet = 1'b0;
    longint cycles = 0;

    function automatic longint sat_u(longint v);
        return v < 0 ? 0 : (v > SMAX ? SMAX : v);
    endfunction

    function automatic longint sat_s(longint v);
        return v < -SMAX ? -SMAX : (v > SMAX ? SMAX : v);
    endfunction

    function automatic int eff_len(longint unsigned l, int depth);
        if (l == 0) return 1;
        if (l > depth) return depth;
        return int'(l);
    endfunction

    function automatic void split_background();
        longint g;
        longint d;
        g = (gran_r == 0) ? 1 : longint'(gran_r);
        d = longint'(lim_r) - resv;
        spare_cur = d % g;
        bg_cur = d - spare_cur;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void window_stats(output longint m, output longint sd);
        longint unsigned n, a, b;
        n = win_cnt;
        m = 0;
        sd = 0;
        if (n != 0) begin
            m = longint'(win_sum / n);
            a = n * win_sq;
            b = win_sum * win_sum;
            sd = (a > b) ? longint'(int_sqrt((a - b) / (n * n))) : 0;
        end
    endfunction

    function automatic longint guard_for(longint sd);
        longint fl, dv;
        fl = longint'((guard_frac_r * lim_r) >> 16);
        dv = longint'((mult_r * longint'(sd)) >> 12);
        return fl > dv ? fl : dv;
    endfunction

    function automatic void window_add(longint unsigned v);
        longint unsigned old;
        if (win_cnt >= eff_len(wlen_r, WDEPTH) && win_cnt > 0) begin
            old = win_mem[win_head];
            win_sum -= old;
            win_sq -= old * old;
            win_head = (win_head + 1) % WDEPTH;
            win_cnt--;
        end
        win_mem[(win_head + win_cnt) % WDEPTH] = v;
        win_sum += v;
        win_sq += v * v;
        win_cnt++;
    endfunction

    function automatic void rebase_reserve(longint m, longint sd);
        longint g;
        g = guard_for(sd);
        resv = sat_u(m + g);
        bound_cur = sat_s(m - g);
        split_background();
    endfunction

    function automatic void reset_predictor();
        lim_r = RST_TOTAL_LIMIT; init_r = RST_INITIAL_RESERVE;
        guard_frac_r = RST_MIN_GUARD; mult_r = RST_GUARD_MULT;
        close_r = RST_CLOSENESS; gran_r = RST_GRANULE;
        wlen_r = RST_WINDOW_LEN; plen_r = RST_PHASE_LEN;
        win_head = 0; win_cnt = 0; win_sum = 0; win_sq = 0; run_cnt = 0;
        resv = init_r;
        split_background();
        bound_cur = 0;
        hold = -1;
        filling_now = 1'b1;
    endfunction

    // expected result of one accepted sample, advancing the predictor
    function automatic reserve_result_t predict_reserve(logic [SBITS-1:0] s);
        reserve_result_t r;
        longint m, sd, g, cur, thr;
        int k, start;
        m = 0; sd = 0;
        r.viol = 0; r.phase = 0; r.fill = 0;
        if (filling_now) begin
            resv = sat_u(longint'(init_r));
            split_background();
            window_add(s);
            r.fill = 1;
            if (win_cnt >= eff_len(wlen_r, WDEPTH)) begin
                window_stats(m, sd);
                rebase_reserve(m, sd);
                filling_now = 0;
                r.fill = 0;
            end
        end else begin
            window_stats(m, sd);
            g = guard_for(sd);
            window_add(s);
            if (hold > 0) hold--;
            if (hold == 0) begin
                bound_cur = sat_s(m - g);
                hold = -1;
            end
            cur = longint'(s);
            thr = longint'(close_r) * resv;
            if (cur * 65536 >= thr) begin
                cur -= spare_cur;
                spare_cur = 0;
            end
            if (cur * 65536 >= thr) begin
                resv = sat_u(cur + g);
                bound_cur = sat_s(cur - g);
                split_background();
                r.viol = 1;
                hold = eff_len(wlen_r, WDEPTH);
            end
            if (cur < bound_cur) begin
                if (run_cnt < RDEPTH) begin
                    run_mem[run_cnt] = longint'(sat_u(cur));
                    run_cnt++;
                end
            end else begin
                run_cnt = 0;
            end
            if (run_cnt >= eff_len(plen_r, RDEPTH)) begin
                k = run_cnt;
                start = (k > WDEPTH) ? k - WDEPTH : 0;
                win_head = 0; win_cnt = 0; win_sum = 0; win_sq = 0;
                for (int i = start; i < k; i++) begin
                    win_mem[win_cnt % WDEPTH] = run_mem[i];
                    win_sum += run_mem[i];
                    win_sq += run_mem[i] * run_mem[i];
                    win_cnt++;
                end
                window_stats(m, sd);
                rebase_reserve(m, sd);
                run_cnt = 0;
                r.phase = 1;
            end
        end
        r.fg = resv[SBITS-1:0];
        r.bg = bg_cur[SBITS:0];
        r.spare = spare_cur[SBITS:0];
        r.bound = bound_cur[SBITS:0];
        r.mean = m[SBITS-1:0];
        r.sd = sd[SBITS-1:0];
        return r;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycles,
                     expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stall in random bursts
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) i_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
            i_stall <= 1'b1;
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        reserve_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result item with none expected");
            end else begin
                e = expected_q.pop_front();
                viol_seen += e.viol;
                phase_seen += e.phase;
                fill_seen += e.fill;
                if (e.fg !== o_fg_reserve || e.bg !== o_bg_reserve
                    || e.spare !== o_bg_spare || e.bound !== o_lower_bound
                    || e.mean !== o_window_mean || e.sd !== o_window_std
                    || e.viol !== o_violation || e.phase !== o_phase_change
                    || e.fill !== o_filling) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch item %0d exp fg=%0d bg=%0d sp=%0d lb=%0d m=%0d sd=%0d v%0d p%0d f%0d",
                                 results_seen, e.fg, e.bg, e.spare, e.bound, e.mean, e.sd,
                                 e.viol, e.phase, e.fill);
                        $display("    got fg=%0d bg=%0d sp=%0d lb=%0d m=%0d sd=%0d v%0d p%0d f%0d",
                                 o_fg_reserve, o_bg_reserve, o_bg_spare, o_lower_bound,
                                 o_window_mean, o_window_std, o_violation,
                                 o_phase_change, o_filling);
                    end
                end
            end
        end
    end

    // present one item, hold it until accepted, then maybe leave a gap
    task automatic send_sample(input logic [SBITS-1:0] s);
        i_sample_mb <= s;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(predict_reserve(s));
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    // block all stimulus until every expected item has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOTAL_LIMIT:     lim_r = d;
            CFG_INITIAL_RESERVE: init_r = d;
            CFG_MIN_GUARD:       guard_frac_r = d[FRAC_W-1:0];
            CFG_GUARD_MULT:      mult_r = d[FRAC_W-1:0];
            CFG_CLOSENESS:       close_r = d[FRAC_W-1:0];
            CFG_GRANULE:         gran_r = d;
            CFG_WINDOW_LEN:      wlen_r = d[LEN_W-1:0];
            CFG_PHASE_LEN:       plen_r = d[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [23:0] lim, input logic [23:0] init,
                           input logic [15:0] gf, input logic [15:0] mult,
                           input logic [15:0] cl, input logic [23:0] gran,
                           input logic [6:0] wl, input logic [6:0] pl);
        write_reg(CFG_TOTAL_LIMIT, lim);
        write_reg(CFG_INITIAL_RESERVE, init);
        write_reg(CFG_MIN_GUARD, gf);
        write_reg(CFG_GUARD_MULT, mult);
        write_reg(CFG_CLOSENESS, cl);
        write_reg(CFG_GRANULE, gran);
        write_reg(CFG_WINDOW_LEN, wl);
        write_reg(CFG_PHASE_LEN, pl);
    endtask

    // memory-use trace: noisy level with spikes and sustained drops
    longint level = 400000;
    int     drop_left = 0;
    function automatic logic [SBITS-1:0] workload_sample();
        longint v, spread;
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) level = $urandom_range(1000, 15000000);
        if (drop_left == 0 && r >= 2 && r < 6) drop_left = $urandom_range(1, 70);
        spread = (level >> 5) + 1;
        v = level + longint'($urandom_range(0, 2 * spread)) - spread;
        if (drop_left > 0) begin
            drop_left--;
            v = v / 3;
        end else if (r >= 6 && r < 12) begin
            v = v * 2;
        end else if (r == 12) begin
            v = $urandom_range(0, SMAX);
        end
        return logic'(sat_u(v)) ? sat_u(v) : sat_u(v);
    endfunction

    // fill with reset registers, then field extremes
    task automatic test_fill_and_extremes();
        repeat (4) send_sample($urandom_range(0, 5000));
        send_sample('0);
        send_sample(SMAX);
        drain();
        set_all(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                7'd3, 7'd2);
        send_sample('0);
        send_sample(SMAX);
        send_sample(24'hAAAAAA);
        send_sample(24'h555555);
        drain();
    endtask

    // spikes near the reserve, spare give-back and hold-off of the bound
    task automatic test_violations();
        set_all(24'd1000000, 24'd500000, 16'd0, 16'd8192, 16'd58982, 24'd0, 7'd0, 7'd0);
        send_sample(24'd500000);
        send_sample(24'd520000);
        send_sample(24'd900000);
        send_sample(24'd505000);
        send_sample(24'd510000);
        drain();
    endtask

    // sustained low samples rebase the window, including a run longer than the window
    task automatic test_phase_changes();
        set_all(24'd2000000, 24'd100000, 16'd2000, 16'd4096, 16'd60000, 24'd4096,
                7'd2, 7'd64);
        send_sample(24'd800000);
        send_sample(24'd820000);
        for (int i = 0; i < 66; i++) send_sample($urandom_range(0, 3000));
        drain();
        write_reg(CFG_WINDOW_LEN, 7'd127);
        write_reg(CFG_PHASE_LEN, 7'd127);
        for (int i = 0; i < 8; i++) send_sample($urandom_range(0, 2000));
        drain();
    endtask

    // random workload over a series of register settings
    task automatic test_random_workload(input int n_items);
        int per_phase;
        per_phase = n_items / 10;
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            quiet = (ph >= 8);
            if (ph == 3) begin
                set_all(24'hFFFFFF, 24'h0, 16'hFFFF, 16'h0, 16'h0, 24'd1, 7'd64, 7'd1);
            end else if (ph == 6) begin
                set_all(24'h0, 24'hFFFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 24'd0, 7'd1, 7'd64);
            end else begin
                set_all($urandom_range(100000, SMAX), $urandom_range(0, SMAX),
                        $urandom_range(0, 6000), $urandom_range(2048, 20000),
                        $urandom_range(40000, 65535), $urandom_range(1, 1 << 16),
                        $urandom_range(1, 20), $urandom_range(1, 8));
                level = $urandom_range(10000, lim_r);
            end
            for (int i = 0; i < per_phase; i++) begin
                if (i == per_phase / 2 && ph == 1) drain();
                send_sample(workload_sample());
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_fill_and_extremes();
        test_violations();
        test_phase_changes();
        test_random_workload(1450);
        drain();
        repeat (300) @(posedge i_clk);
        $display("covered %0d result items: %0d filling, %0d reserve raises, %0d rebases",
                 results_seen, fill_seen, viol_seen, phase_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d items never returned", mismatches,
                     expected_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/amrt_pkg.sv
sv/amrt_ram.sv
sv/adaptive_memory_reserve_tracker.sv
tb/adaptive_memory_reserve_tracker_tb.sv
